// ----- design/tom_pkg.sv -----
// Tone oscillator mixer: shared types, register codes and the sine table
// entry function used at elaboration.
// No dependencies.
package tom_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_WAVEFORM    = 2'd0,
        CFG_PHASE_STEP  = 2'd1,
        CFG_HALF_PERIOD = 2'd2,
        CFG_VOLUME      = 2'd3
    } t_cfg_reg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int SAMPLE_W   = 32;
    localparam int STEP_W     = 32;
    localparam int HP_W       = 24;
    localparam int VOL_W      = 16;
    localparam int TAB_W      = 15;
    localparam int PROD_W     = TAB_W + VOL_W;
    localparam int SUM_W      = SAMPLE_W + 2;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Waveform select
    localparam logic WAVE_SINE   = 1'b0;
    localparam logic WAVE_SQUARE = 1'b1;

    // Live configuration
    typedef struct packed {
        logic              waveform;
        logic [STEP_W-1:0] phase_step;
        logic [HP_W-1:0]   half_period;
        logic [VOL_W-1:0]  volume;
    } t_cfg;

    // Side-band carried along the pipeline with each sample
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       sine_neg;
        logic                       sq_neg;
    } t_side;

    // Quarter-wave sine entry in Q0.15 for angle x in Q30, Taylor series to x^15
    function automatic logic [TAB_W-1:0] sine_entry(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [63:0] s;
        logic [63:0]        v;
        x2 = (x * x) >> 30;
        t  = x;
        s  = $signed(x);
        t  = ((t * x2) >> 30) / 64'd6;
        s  = s - $signed(t);
        t  = ((t * x2) >> 30) / 64'd20;
        s  = s + $signed(t);
        t  = ((t * x2) >> 30) / 64'd42;
        s  = s - $signed(t);
        t  = ((t * x2) >> 30) / 64'd72;
        s  = s + $signed(t);
        t  = ((t * x2) >> 30) / 64'd110;
        s  = s - $signed(t);
        t  = ((t * x2) >> 30) / 64'd156;
        s  = s + $signed(t);
        t  = ((t * x2) >> 30) / 64'd210;
        s  = s - $signed(t);
        if (s < 0) begin
            s = 64'sd0;
        end
        v = ($unsigned(s) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[TAB_W-1:0];
    endfunction

endpackage

// ----- design/tone_oscillator_mixer_core.sv -----
// Tone oscillator mixer, top level: adds a sine or square tone to a stream
// of signed 32-bit samples. Depends on tom_pkg and the tom_* submodules.
//
// One sample is accepted every clock cycle unless the input is stalled. The
// path has four pipeline registers: phase and table index, sine table read,
// volume multiply, and add with saturation. The first of these is loaded at
// the accepting edge itself. Each stage has its own valid bit and moves
// whenever the stage after it is empty or moving. Bubbles therefore close up
// behind a stalled result, and input is stalled only when all four stages hold
// samples and the result is stalled. Configuration writes are taken in any cycle
// (ready is always high) but are meant for an idle pipeline.
module tone_oscillator_mixer_core import tom_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int PHASE_WIDTH      = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input sample channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    input  logic                       i_restart,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    output logic                       o_saturated,
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);

    t_cfg             cfg;
    logic [IDX_W-1:0] a_idx;
    t_side            a_side;
    logic [TAB_W-1:0] b_tab;

    logic  r_a_valid;
    logic  r_b_valid;
    logic  r_c_valid;
    logic  r_o_valid;
    t_side r_b_side;
    t_side r_c_side;

    logic free_o;
    logic rdy_c;
    logic rdy_b;
    logic rdy_a;
    logic w_accept;
    logic ld_b;
    logic ld_c;
    logic ld_o;

    // Pipeline flow control
    always_comb begin
        free_o   = !r_o_valid || !i_out_stall;
        rdy_c    = !r_c_valid || free_o;
        rdy_b    = !r_b_valid || rdy_c;
        rdy_a    = !r_a_valid || rdy_b;
        w_accept = i_in_valid && rdy_a;
        ld_b     = r_a_valid && rdy_b;
        ld_c     = r_b_valid && rdy_c;
        ld_o     = r_c_valid && free_o;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_a_valid <= i_in_valid;
            end
            if (rdy_b) begin
                r_b_valid <= r_a_valid;
            end
            if (rdy_c) begin
                r_c_valid <= r_b_valid;
            end
            if (free_o) begin
                r_o_valid <= r_c_valid;
            end
        end
    end

    // Side-band follows the sample through the table and multiply stages
    always_ff @(posedge i_clk) begin
        if (ld_b) begin
            r_b_side <= a_side;
        end
        if (ld_c) begin
            r_c_side <= r_b_side;
        end
    end

    tom_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tom_phase_gen #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .PHASE_WIDTH      (PHASE_WIDTH),
        .IDX_W            (IDX_W)
    ) u_phase_gen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_accept),
        .i_restart (i_restart),
        .i_sample  (i_sample_in),
        .i_cfg     (cfg),
        .o_idx     (a_idx),
        .o_side    (a_side)
    );

    tom_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .IDX_W            (IDX_W)
    ) u_sine_rom (
        .i_clk  (i_clk),
        .i_en   (ld_b),
        .i_addr (a_idx),
        .o_data (b_tab)
    );

    tom_mix_sat u_mix_sat (
        .i_clk        (i_clk),
        .i_load_mul   (ld_c),
        .i_load_out   (ld_o),
        .i_tab        (b_tab),
        .i_side       (r_c_side),
        .i_cfg        (cfg),
        .o_sample_out (o_sample_out),
        .o_saturated  (o_saturated)
    );

    assign o_in_stall  = !rdy_a;
    assign o_out_valid = r_o_valid;
    assign o_cfg_ready = 1'b1;

    // A free result side never holds back input
    a_no_stall_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_stall |-> !o_in_stall)
        else $error("input stalled while result side is free");

    // A clipped result sits at one of the int32 limits
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_sample_out == 32'sh7FFFFFFF || o_sample_out == 32'sh80000000))
        else $error("saturation flag without a clipped value");

    // Restart gives phase zero and a positive square for that sample
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_restart) |=> (!a_side.sine_neg && !a_side.sq_neg))
        else $error("restart did not clear generator state");

    // A sample in the first stage moves on when the second is empty
    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !r_b_valid) |=> r_b_valid)
        else $error("pipeline stage failed to advance");

endmodule

// ----- design/tom_cfg_regs.sv -----
// Tone oscillator mixer: configuration register file.
// Depends on tom_pkg.
module tom_cfg_regs import tom_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Register writes, one transaction per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.waveform    <= WAVE_SINE;
            r_cfg.phase_step  <= '0;
            r_cfg.half_period <= HP_W'(1);
            r_cfg.volume      <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_WAVEFORM:    r_cfg.waveform    <= i_cfg_data[0];
                CFG_PHASE_STEP:  r_cfg.phase_step  <= i_cfg_data[STEP_W-1:0];
                CFG_HALF_PERIOD: r_cfg.half_period <= i_cfg_data[HP_W-1:0];
                CFG_VOLUME:      r_cfg.volume      <= i_cfg_data[VOL_W-1:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- design/tom_phase_gen.sv -----
// Tone oscillator mixer: phase accumulator, square half-period counter and
// sine table index, registered as the first pipeline stage.
// Depends on tom_pkg.
module tom_phase_gen import tom_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int PHASE_WIDTH      = 32,
    parameter int IDX_W            = $clog2(SINE_TABLE_DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  logic                       i_restart,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  t_cfg                       i_cfg,
    output logic [IDX_W-1:0]           o_idx,
    output t_side                      o_side
);

    localparam int FRAC_W = PHASE_WIDTH - 2;
    localparam int MUL_W  = FRAC_W + IDX_W;

    logic [PHASE_WIDTH-1:0] r_accum;
    logic [HP_W-1:0]        r_count;
    logic                   r_sq_neg;
    logic [IDX_W-1:0]       r_idx;
    t_side                  r_side;

    logic [PHASE_WIDTH-1:0] cur_phase;
    logic [HP_W-1:0]        cur_count;
    logic                   cur_sq_neg;
    logic [HP_W-1:0]        hp;
    logic [HP_W-1:0]        count_inc;
    logic [1:0]             quad;
    logic [MUL_W-1:0]       frac_scaled;
    logic [IDX_W-1:0]       idx_raw;
    logic [IDX_W-1:0]       idx;
    logic [PHASE_WIDTH-1:0] n_accum;
    logic [HP_W-1:0]        n_count;
    logic                   n_sq_neg;

    // Current state, cleared by restart before use
    always_comb begin
        cur_phase  = i_restart ? '0 : r_accum;
        cur_count  = i_restart ? '0 : r_count;
        cur_sq_neg = i_restart ? 1'b0 : r_sq_neg;
        hp         = (i_cfg.half_period == '0) ? HP_W'(1) : i_cfg.half_period;
        count_inc  = cur_count + HP_W'(1);
        n_accum    = cur_phase + PHASE_WIDTH'(i_cfg.phase_step);
        if (count_inc >= hp) begin
            n_count  = '0;
            n_sq_neg = ~cur_sq_neg;
        end else begin
            n_count  = count_inc;
            n_sq_neg = cur_sq_neg;
        end
    end

    // Quadrant and table index, mirrored in odd quadrants
    always_comb begin
        quad        = cur_phase[PHASE_WIDTH-1 -: 2];
        frac_scaled = MUL_W'(cur_phase[FRAC_W-1:0]) * MUL_W'(SINE_TABLE_DEPTH);
        idx_raw     = frac_scaled[FRAC_W +: IDX_W];
        idx         = quad[0] ? (IDX_W'(SINE_TABLE_DEPTH - 1) - idx_raw) : idx_raw;
    end

    // Generator state, advanced on every accepted sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum  <= '0;
            r_count  <= '0;
            r_sq_neg <= 1'b0;
        end else if (i_load) begin
            r_accum  <= n_accum;
            r_count  <= n_count;
            r_sq_neg <= n_sq_neg;
        end
    end

    // Stage register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_idx           <= idx;
            r_side.sample   <= i_sample;
            r_side.sine_neg <= quad[1];
            r_side.sq_neg   <= cur_sq_neg;
        end
    end

    assign o_idx  = r_idx;
    assign o_side = r_side;

endmodule

// ----- design/tom_sine_rom.sv -----
// Tone oscillator mixer: quarter-wave sine table, Q0.15, registered read.
// Depends on tom_pkg (sine_entry, HALF_PI_Q30).
module tom_sine_rom import tom_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int IDX_W            = $clog2(SINE_TABLE_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [IDX_W-1:0] i_addr,
    output logic [TAB_W-1:0] o_data
);

    logic [TAB_W-1:0] tab [SINE_TABLE_DEPTH];
    logic [TAB_W-1:0] r_data;

    // Table contents worked out at elaboration, angle at the entry's centre
    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_tab
        localparam logic [63:0] ANGLE =
            (64'(2 * g + 1) * HALF_PI_Q30) / 64'(2 * SINE_TABLE_DEPTH);
        assign tab[g] = sine_entry(ANGLE);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= tab[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

// ----- design/tom_mix_sat.sv -----
// Tone oscillator mixer: volume multiply stage, then tone select, add and
// int32 saturation into the result register.
// Depends on tom_pkg.
module tom_mix_sat import tom_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_load_mul,
    input  logic                       i_load_out,
    input  logic [TAB_W-1:0]           i_tab,
    input  t_side                      i_side,
    input  t_cfg                       i_cfg,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    output logic                       o_saturated
);

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(64'sd2147483648);

    logic [PROD_W-1:0]          r_prod;
    logic signed [SAMPLE_W-1:0] r_sample_out;
    logic                       r_saturated;

    logic signed [SUM_W-1:0] tone_mag;
    logic signed [SUM_W-1:0] tone;
    logic signed [SUM_W-1:0] sum;
    logic signed [SAMPLE_W-1:0] n_sample_out;
    logic                       n_saturated;

    // Sine magnitude times volume
    always_ff @(posedge i_clk) begin
        if (i_load_mul) begin
            r_prod <= PROD_W'(i_tab) * PROD_W'(i_cfg.volume);
        end
    end

    // Tone select and signed, saturating add
    always_comb begin
        if (i_cfg.waveform == WAVE_SQUARE) begin
            tone_mag = $signed({2'b00, i_cfg.volume, 16'h0000});
            tone     = i_side.sq_neg ? -tone_mag : tone_mag;
        end else begin
            tone_mag = $signed({2'b00, r_prod, 1'b0});
            tone     = i_side.sine_neg ? -tone_mag : tone_mag;
        end
        sum = SUM_W'(i_side.sample) + tone;
        if (sum > SUM_MAX) begin
            n_sample_out = SUM_MAX[SAMPLE_W-1:0];
            n_saturated  = 1'b1;
        end else if (sum < SUM_MIN) begin
            n_sample_out = SUM_MIN[SAMPLE_W-1:0];
            n_saturated  = 1'b1;
        end else begin
            n_sample_out = sum[SAMPLE_W-1:0];
            n_saturated  = 1'b0;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_load_out) begin
            r_sample_out <= n_sample_out;
            r_saturated  <= n_saturated;
        end
    end

    assign o_sample_out = r_sample_out;
    assign o_saturated  = r_saturated;

endmodule
